// File: sv/tcse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS ClientHello SNI extractor package
// Beat types, protocol constants and the event format passed from the parser
// to the result stage.
// ----------------------------------------------------------------------------
package tcse_pkg;

   // One input beat: a payload byte with its packet context.
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic [15:0] payload_length;
      logic        end_of_packet;
   } req_type;

   // One result beat: either a host name character or the packet verdict.
   typedef struct packed {
      logic       result_kind;
      logic [7:0] name_byte;
      logic [7:0] name_index;
      logic [7:0] name_length;
      logic       identified;
      logic       packet_done;
   } rsp_type;

   // Everything one input byte produced, as queued between parser and output.
   typedef struct packed {
      logic       has_name;
      logic [7:0] name_byte;
      logic [7:0] name_index;
      logic [7:0] name_length;
      logic       has_verdict;
      logic       verdict_ok;
      logic [7:0] verdict_length;
   } evt_type;

   // Result kinds.
   localparam logic KIND_NAME    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // Record and handshake header checks.
   localparam logic [7:0]  REC_TYPE_HANDSHAKE = 8'h16;
   localparam logic [7:0]  REC_VERSION_MAJOR  = 8'h03;
   localparam logic [7:0]  HS_CLIENT_HELLO    = 8'h01;
   localparam logic [16:0] POS_RECORD_TYPE    = 17'd0;
   localparam logic [16:0] POS_VERSION_MAJOR  = 17'd1;
   localparam logic [16:0] POS_HS_TYPE        = 17'd5;
   localparam logic [16:0] POS_SESSION_ID_LEN = 17'd43;
   localparam logic [15:0] MIN_PAYLOAD_LENGTH = 16'd44;
   localparam logic [17:0] SESSION_ID_START   = 18'd44;

   // Extension and server_name entry codes.
   localparam logic [15:0] EXT_SERVER_NAME    = 16'h0000;
   localparam logic [15:0] SNI_MIN_EXT_LENGTH = 16'd5;
   localparam logic [7:0]  NAME_TYPE_HOST     = 8'h00;

   // Event queue between the parser and the result stage.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

endpackage

// File: sv/tcse_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS ClientHello SNI parser
// Walks the ClientHello one byte per beat and queues the name bytes and the
// end-of-packet verdict that each byte produces.
// ----------------------------------------------------------------------------
module tcse_parse #(
   parameter int MAX_DOMAIN = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             beat,
   input  tcse_pkg::req_type req_data,
   output logic             evt_push,
   output tcse_pkg::evt_type evt_data
);

   typedef enum logic [3:0] {
      PH_HDR, PH_CS_HI, PH_CS_LO, PH_CM, PH_EX_HI, PH_EX_LO, PH_ET_HI, PH_ET_LO,
      PH_EL_HI, PH_EL_LO, PH_NTYPE, PH_NL_HI, PH_NL_LO, PH_NAME, PH_DONE
   } phase_type;

   localparam logic [15:0] NAME_LIMIT = 16'(MAX_DOMAIN);
   localparam logic [7:0]  NAME_KEEP  = 8'(MAX_DOMAIN - 1);

   phase_type phase_ff, phase_in;
   logic [16:0] pos_ff, pos_in;
   logic [17:0] target_ff, target_in;
   logic [17:0] exts_end_ff, exts_end_in;
   logic [17:0] ext_end_ff, ext_end_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic [15:0] ext_kind_ff, ext_kind_in;
   logic [7:0]  kept_ff, kept_in;
   logic [7:0]  emit_ff, emit_in;
   logic        found_ff, found_in;

   logic [7:0]  b;
   logic [17:0] len18;
   logic [17:0] p18;
   logic [15:0] v;
   logic [17:0] v18;
   logic [17:0] ext_span;
   logic        ok;
   tcse_pkg::evt_type evt;

   // True when the next extension header starting at pos fits the list.
   function automatic logic ext_fits(input logic [17:0] pos, input logic [17:0] lim);
      return (pos + 18'd4) <= lim;
   endfunction

   assign b     = req_data.payload_byte;
   assign len18 = {2'b00, req_data.payload_length};
   assign p18   = {1'b0, pos_ff};
   assign v     = {len_hi_ff, b};
   assign v18   = {2'b00, v};

   // Per-byte parse step.
   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      target_in   = target_ff;
      exts_end_in = exts_end_ff;
      ext_end_in  = ext_end_ff;
      len_hi_in   = len_hi_ff;
      ext_kind_in = ext_kind_ff;
      kept_in     = kept_ff;
      emit_in     = emit_ff;
      found_in    = found_ff;
      ext_span    = p18 + 18'd1 + v18;
      ok          = 1'b0;
      evt         = '0;

      if (beat) begin
         if (phase_ff == PH_HDR) begin
            if ((pos_ff == tcse_pkg::POS_RECORD_TYPE &&
                 (req_data.payload_length < tcse_pkg::MIN_PAYLOAD_LENGTH ||
                  b != tcse_pkg::REC_TYPE_HANDSHAKE)) ||
                (pos_ff == tcse_pkg::POS_VERSION_MAJOR && b != tcse_pkg::REC_VERSION_MAJOR) ||
                (pos_ff == tcse_pkg::POS_HS_TYPE && b != tcse_pkg::HS_CLIENT_HELLO)) begin
               phase_in = PH_DONE;
            end else if (pos_ff == tcse_pkg::POS_SESSION_ID_LEN) begin
               target_in = tcse_pkg::SESSION_ID_START + {10'd0, b};
               phase_in  = ((target_in + 18'd2) > len18) ? PH_DONE : PH_CS_HI;
            end
         end else if (phase_ff != PH_DONE && p18 == target_ff) begin
            case (phase_ff)
               PH_CS_HI, PH_EX_HI, PH_ET_HI, PH_EL_HI, PH_NL_HI: begin
                  len_hi_in = b;
                  target_in = p18 + 18'd1;
                  case (phase_ff)
                     PH_CS_HI: phase_in = PH_CS_LO;
                     PH_EX_HI: phase_in = PH_EX_LO;
                     PH_ET_HI: phase_in = PH_ET_LO;
                     PH_EL_HI: phase_in = PH_EL_LO;
                     default:  phase_in = PH_NL_LO;
                  endcase
               end
               PH_CS_LO: begin
                  target_in = ext_span;
                  phase_in  = ((target_in + 18'd1) > len18) ? PH_DONE : PH_CM;
               end
               PH_CM: begin
                  target_in = p18 + 18'd1 + {10'd0, b};
                  phase_in  = ((target_in + 18'd2) > len18) ? PH_DONE : PH_EX_HI;
               end
               PH_EX_LO: begin
                  // The extension list is clipped to the payload length.
                  exts_end_in = (ext_span > len18) ? len18 : ext_span;
                  if (ext_fits(p18 + 18'd1, exts_end_in)) begin
                     target_in = p18 + 18'd1;
                     phase_in  = PH_ET_HI;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_ET_LO: begin
                  ext_kind_in = v;
                  target_in   = p18 + 18'd1;
                  phase_in    = PH_EL_HI;
               end
               PH_EL_LO: begin
                  ext_end_in = ext_span;
                  if (ext_span > exts_end_ff) begin
                     phase_in = PH_DONE;
                  end else if (ext_kind_ff == tcse_pkg::EXT_SERVER_NAME &&
                               v >= tcse_pkg::SNI_MIN_EXT_LENGTH) begin
                     // Skip the two-byte server name list length.
                     target_in = p18 + 18'd3;
                     phase_in  = PH_NTYPE;
                  end else if (ext_fits(ext_span, exts_end_ff)) begin
                     target_in = ext_span;
                     phase_in  = PH_ET_HI;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_NTYPE: begin
                  if (b != tcse_pkg::NAME_TYPE_HOST) begin
                     if (ext_fits(ext_end_ff, exts_end_ff)) begin
                        target_in = ext_end_ff;
                        phase_in  = PH_ET_HI;
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end else begin
                     target_in = p18 + 18'd1;
                     phase_in  = PH_NL_HI;
                  end
               end
               PH_NL_LO: begin
                  if (v != 16'd0 && ext_span <= ext_end_ff) begin
                     kept_in   = (v >= NAME_LIMIT) ? NAME_KEEP : v[7:0];
                     emit_in   = 8'd0;
                     found_in  = 1'b1;
                     target_in = p18 + 18'd1;
                     phase_in  = PH_NAME;
                  end else if (ext_fits(ext_end_ff, exts_end_ff)) begin
                     target_in = ext_end_ff;
                     phase_in  = PH_ET_HI;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_NAME: begin
                  evt.has_name    = 1'b1;
                  evt.name_byte   = b;
                  evt.name_index  = emit_ff;
                  evt.name_length = kept_ff;
                  emit_in         = emit_ff + 8'd1;
                  target_in       = p18 + 18'd1;
                  if (emit_in >= kept_ff) begin
                     phase_in = PH_DONE;
                  end
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
         end

         // The byte position saturates rather than wrapping.
         if (pos_ff != '1) begin
            pos_in = pos_ff + 17'd1;
         end

         // End of packet: report the verdict and start over.
         if (req_data.end_of_packet) begin
            ok                 = found_in && (emit_in >= kept_in);
            evt.has_verdict    = 1'b1;
            evt.verdict_ok     = ok;
            evt.verdict_length = ok ? kept_in : 8'd0;
            phase_in           = PH_HDR;
            pos_in             = '0;
            target_in          = '0;
            exts_end_in        = '0;
            ext_end_in         = '0;
            len_hi_in          = '0;
            ext_kind_in        = '0;
            kept_in            = '0;
            emit_in            = '0;
            found_in           = 1'b0;
         end
      end
   end

   assign evt_push = beat && (evt.has_name || evt.has_verdict);
   assign evt_data = evt;

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR;
         pos_ff      <= '0;
         target_ff   <= '0;
         exts_end_ff <= '0;
         ext_end_ff  <= '0;
         len_hi_ff   <= '0;
         ext_kind_ff <= '0;
         kept_ff     <= '0;
         emit_ff     <= '0;
         found_ff    <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         target_ff   <= target_in;
         exts_end_ff <= exts_end_in;
         ext_end_ff  <= ext_end_in;
         len_hi_ff   <= len_hi_in;
         ext_kind_ff <= ext_kind_in;
         kept_ff     <= kept_in;
         emit_ff     <= emit_in;
         found_ff    <= found_in;
      end
   end

endmodule

// File: sv/tcse_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS ClientHello SNI event queue
// A short show-ahead queue that decouples the parser from the result stage.
// ----------------------------------------------------------------------------
module tcse_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcse_pkg::evt_type push_data,
   input  logic              pop,
   output tcse_pkg::evt_type head,
   output logic              empty,
   output logic              full
);

   tcse_pkg::evt_type mem_ff [tcse_pkg::QUEUE_DEPTH];
   logic [tcse_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tcse_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tcse_pkg::QUEUE_AW:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (tcse_pkg::QUEUE_AW+1)'(tcse_pkg::QUEUE_DEPTH));
   assign head  = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/tcse_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS ClientHello SNI result stage
// Turns queued events into result beats, a name byte before its verdict,
// through a registered output.
// ----------------------------------------------------------------------------
module tcse_emit (
   input  logic              clock,
   input  logic              reset,
   input  tcse_pkg::evt_type head,
   input  logic              empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcse_pkg::rsp_type rsp_data
);

   logic              rsp_valid_ff, rsp_valid_in;
   tcse_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              pend_ff, pend_in;
   logic              pend_ok_ff, pend_ok_in;
   logic [7:0]        pend_len_ff, pend_len_in;
   logic              slot_free;

   function automatic tcse_pkg::rsp_type make_verdict(input logic ok,
                                                      input logic [7:0] len);
      tcse_pkg::rsp_type r;
      r             = '0;
      r.result_kind = tcse_pkg::KIND_VERDICT;
      r.name_length = len;
      r.identified  = ok;
      r.packet_done = 1'b1;
      return r;
   endfunction

   function automatic tcse_pkg::rsp_type make_name(input tcse_pkg::evt_type e);
      tcse_pkg::rsp_type r;
      r             = '0;
      r.result_kind = tcse_pkg::KIND_NAME;
      r.name_byte   = e.name_byte;
      r.name_index  = e.name_index;
      r.name_length = e.name_length;
      return r;
   endfunction

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Load the output register from a held verdict first, then from the queue.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      pend_in      = pend_ff;
      pend_ok_in   = pend_ok_ff;
      pend_len_in  = pend_len_ff;
      pop          = 1'b0;
      if (slot_free) begin
         rsp_valid_in = 1'b0;
         if (pend_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = make_verdict(pend_ok_ff, pend_len_ff);
            pend_in      = 1'b0;
         end else if (!empty) begin
            pop          = 1'b1;
            rsp_valid_in = 1'b1;
            if (head.has_name) begin
               rsp_data_in = make_name(head);
               pend_in     = head.has_verdict;
               pend_ok_in  = head.verdict_ok;
               pend_len_in = head.verdict_length;
            end else begin
               rsp_data_in = make_verdict(head.verdict_ok, head.verdict_length);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      rsp_data_ff <= rsp_data_in;
      pend_ok_ff  <= pend_ok_in;
      pend_len_ff <= pend_len_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: sv/tls_client_hello_sni_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS ClientHello SNI extractor
// Finds the server_name host name in a TLS ClientHello payload.
// ----------------------------------------------------------------------------
// The req channel carries one payload byte per beat with the total payload
// length and an end-of-packet mark on the last byte. The rsp channel returns
// the kept host name characters as they arrive (at most MAX_DOMAIN-1) and one
// verdict beat per packet, the last result of that packet.
// A byte is accepted every cycle while the four-entry event queue has room;
// the parser handles each byte in the cycle it is accepted. A result passes
// through the event queue and then the output register on its way to rsp. A
// byte that yields both a name character and the verdict gives the name beat
// first; the output sends one result beat per cycle while rsp_ready is high.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and req_ready drops once four events are waiting.
// Reset clears the parser to the record header check, empties the queue and
// drops rsp_valid; with the queue empty, req_ready is high after reset.
// ----------------------------------------------------------------------------
module tls_client_hello_sni_extractor #(
   parameter int MAX_DOMAIN = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcse_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcse_pkg::rsp_type rsp_data
);

   logic              beat;
   logic              evt_push;
   tcse_pkg::evt_type evt_data;
   tcse_pkg::evt_type head;
   logic              empty;
   logic              full;
   logic              pop;

   assign req_ready = !full;
   assign beat      = req_valid && req_ready;

   tcse_parse #(
      .MAX_DOMAIN(MAX_DOMAIN)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .beat     (beat),
      .req_data (req_data),
      .evt_push (evt_push),
      .evt_data (evt_data)
   );

   tcse_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (evt_push),
      .push_data (evt_data),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   tcse_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sv/tcse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS ClientHello SNI extractor checker
// Port-level checks on the extractor, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tcse_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input tcse_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tcse_pkg::rsp_type rsp_data
);

   // A stalled result beat stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // Reset leaves the output empty and the request side ready.
   assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("extractor not idle after reset");

   // A name character never carries verdict flags.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == tcse_pkg::KIND_NAME
         |-> !rsp_data.packet_done && !rsp_data.identified)
      else $error("name beat marked as verdict");

   // A name character lies within the kept name length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == tcse_pkg::KIND_NAME
         |-> rsp_data.name_index < rsp_data.name_length)
      else $error("name index beyond kept length");

   // A verdict that names nothing reports zero length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == tcse_pkg::KIND_VERDICT
         |-> rsp_data.packet_done && (rsp_data.identified || rsp_data.name_length == 8'd0))
      else $error("verdict fields inconsistent");

endmodule

bind tls_client_hello_sni_extractor tcse_checker u_tcse_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS ClientHello SNI extractor testbench
// Drives whole payloads byte by byte into the extractor. The payloads are
// hand-built ClientHello records, some with a planted fault and some pure
// noise. A scoreboard tracks the parse alongside the block and checks every
// host name and verdict beat in order. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import tcse_pkg::*;

   localparam int NAME_LIMIT     = 256;
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int TAIL_CYCLES    = 16;
   localparam int RANDOM_BYTES   = 600;
   localparam int RANDOM_PACKETS = 16;
   localparam int MAX_IDLE       = 14;

   // Parse steps of the extractor, in the order a well-formed hello visits them.
   typedef enum logic [3:0] {
      PS_HEADER, PS_CS_HI, PS_CS_LO, PS_CM, PS_EX_HI, PS_EX_LO, PS_ET_HI, PS_ET_LO,
      PS_EL_HI, PS_EL_LO, PS_NAME_TYPE, PS_NL_HI, PS_NL_LO, PS_NAME, PS_DONE
   } parse_step_e;

   // Faults that the hello builder can plant.
   typedef enum int {
      FLAW_NONE, FLAW_NAME_TYPE, FLAW_EMPTY_NAME, FLAW_NAME_PAST_EXT, FLAW_SHORT_SNI_EXT,
      FLAW_EXT_OVERRUN, FLAW_LIST_LONG, FLAW_LIST_SHORT
   } hello_flaw_e;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Tracks the parse of the current packet and holds the beats it must produce.
   class sni_scoreboard;
      bit [16:0]   byte_pos;
      parse_step_e step;
      bit [17:0]   field_pos;
      bit [17:0]   list_end;
      bit [17:0]   ext_end;
      bit [7:0]    len_hi;
      bit [15:0]   ext_type;
      bit [7:0]    kept_len;
      bit [7:0]    sent_count;
      bit          found;
      rsp_type     expected_beats[$];
      int          mismatches;
      int          beats_seen;
      int          name_beats;
      int          verdict_beats;
      int          hosts_found;

      function void clear();
         byte_pos   = '0;
         step       = PS_HEADER;
         field_pos  = '0;
         list_end   = '0;
         ext_end    = '0;
         len_hi     = '0;
         ext_type   = '0;
         kept_len   = '0;
         sent_count = '0;
         found      = 1'b0;
      endfunction

      function rsp_type make_beat(logic kind, logic [7:0] nb, logic [7:0] ni,
                                  logic [7:0] nl, logic id, logic done);
         rsp_type r;
         r.result_kind = kind;
         r.name_byte   = nb;
         r.name_index  = ni;
         r.name_length = nl;
         r.identified  = id;
         r.packet_done = done;
         return r;
      endfunction

      // Move on to the extension at pos, or stop if its header cannot fit.
      function void start_extension(int unsigned pos);
         if (pos + 4 <= list_end) begin
            field_pos = pos;
            step      = PS_ET_HI;
         end else begin
            step = PS_DONE;
         end
      endfunction

      // Advance the parse by one accepted byte and queue what it yields.
      function void note_byte(req_type d);
         int unsigned p;
         int unsigned len;
         int unsigned v;
         logic [7:0]  b;
         bit          ok;
         p   = byte_pos;
         len = d.payload_length;
         b   = d.payload_byte;
         if (step == PS_HEADER) begin
            if ((p == POS_RECORD_TYPE && (len < MIN_PAYLOAD_LENGTH || b != REC_TYPE_HANDSHAKE)) ||
                (p == POS_VERSION_MAJOR && b != REC_VERSION_MAJOR) ||
                (p == POS_HS_TYPE && b != HS_CLIENT_HELLO)) begin
               step = PS_DONE;
            end else if (p == POS_SESSION_ID_LEN) begin
               field_pos = SESSION_ID_START + b;
               step = (field_pos + 2 > len) ? PS_DONE : PS_CS_HI;
            end
         end else if (step != PS_DONE && p == field_pos) begin
            v = {len_hi, b};
            case (step)
               PS_CS_HI, PS_EX_HI, PS_ET_HI, PS_EL_HI, PS_NL_HI: begin
                  len_hi    = b;
                  field_pos = p + 1;
                  step      = parse_step_e'(step + 1);
               end
               PS_CS_LO: begin
                  field_pos = p + 1 + v;
                  step = (field_pos + 1 > len) ? PS_DONE : PS_CM;
               end
               PS_CM: begin
                  field_pos = p + 1 + b;
                  step = (field_pos + 2 > len) ? PS_DONE : PS_EX_HI;
               end
               PS_EX_LO: begin
                  // The extension list is clipped to the payload length.
                  list_end = (p + 1 + v > len) ? len : p + 1 + v;
                  start_extension(p + 1);
               end
               PS_ET_LO: begin
                  ext_type  = v;
                  field_pos = p + 1;
                  step      = PS_EL_HI;
               end
               PS_EL_LO: begin
                  ext_end = p + 1 + v;
                  if (ext_end > list_end) begin
                     step = PS_DONE;
                  end else if (ext_type == EXT_SERVER_NAME && v >= SNI_MIN_EXT_LENGTH) begin
                     // Skip the server name list length.
                     field_pos = p + 3;
                     step      = PS_NAME_TYPE;
                  end else begin
                     start_extension(ext_end);
                  end
               end
               PS_NAME_TYPE: begin
                  if (b != NAME_TYPE_HOST) begin
                     start_extension(ext_end);
                  end else begin
                     field_pos = p + 1;
                     step      = PS_NL_HI;
                  end
               end
               PS_NL_LO: begin
                  if (v > 0 && p + 1 + v <= ext_end) begin
                     kept_len   = (v >= NAME_LIMIT) ? NAME_LIMIT - 1 : v;
                     sent_count = '0;
                     found      = 1'b1;
                     field_pos  = p + 1;
                     step       = PS_NAME;
                  end else begin
                     start_extension(ext_end);
                  end
               end
               PS_NAME: begin
                  expected_beats.push_back(make_beat(KIND_NAME, b, sent_count, kept_len,
                                                     1'b0, 1'b0));
                  sent_count++;
                  field_pos = p + 1;
                  if (sent_count >= kept_len) begin
                     step = PS_DONE;
                  end
               end
               default: begin
                  step = PS_DONE;
               end
            endcase
         end
         if (byte_pos != 17'h1FFFF) begin
            byte_pos++;
         end
         // The end mark always closes the packet with a verdict.
         if (d.end_of_packet) begin
            ok = found && sent_count >= kept_len;
            expected_beats.push_back(make_beat(KIND_VERDICT, 8'h00, 8'h00,
                                               ok ? kept_len : 8'h00, ok, 1'b1));
            clear();
         end
      endfunction

      task report(string msg);
         if (mismatches < 40) begin
            $display("ERROR result beat %0d: %s", beats_seen, msg);
         end
         mismatches++;
      endtask

      task compare_field(string field, logic [7:0] got, logic [7:0] want);
         if (got !== want) begin
            report($sformatf("%s is %0h, expected %0h", field, got, want));
         end
      endtask

      // Compare an accepted result beat with the oldest expected one.
      task check_beat(rsp_type got);
         rsp_type want;
         beats_seen++;
         if (expected_beats.size() == 0) begin
            report("result beat arrived with nothing expected");
            return;
         end
         want = expected_beats.pop_front();
         compare_field("result_kind", got.result_kind, want.result_kind);
         compare_field("name_byte", got.name_byte, want.name_byte);
         compare_field("name_index", got.name_index, want.name_index);
         compare_field("name_length", got.name_length, want.name_length);
         compare_field("identified", got.identified, want.identified);
         compare_field("packet_done", got.packet_done, want.packet_done);
         if (want.result_kind == KIND_NAME) begin
            name_beats++;
         end else begin
            verdict_beats++;
            if (want.identified) begin
               hosts_found++;
            end
         end
      endtask
   endclass

   sni_scoreboard sb = new;

   logic [7:0]  pkt[$];
   logic [7:0]  ext_bytes[$];
   logic [15:0] pkt_len;
   int          bytes_sent = 0;
   int          packets_sent = 0;
   int          cycle_count = 0;
   bit          send_no_gap;

   tls_client_hello_sni_extractor #(
      .MAX_DOMAIN(NAME_LIMIT)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // Clock with an 8 ns period.
   initial begin
      clock = 1'b0;
   end
   always #4 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL tls_client_hello_sni_extractor");
         $finish;
      end
   end

   // Packet construction helpers.
   function automatic void ext_word(int unsigned v);
      ext_bytes.push_back(v[15:8]);
      ext_bytes.push_back(v[7:0]);
   endfunction

   function automatic void add_plain_ext(int unsigned claimed, int unsigned body);
      ext_word($urandom_range(1, 16'hFFFF));
      ext_word(claimed);
      repeat (body) ext_bytes.push_back($urandom_range(0, 255));
   endfunction

   function automatic void add_sni_ext(logic [7:0] name_type, int unsigned claimed,
                                       int unsigned actual);
      ext_word(EXT_SERVER_NAME);
      ext_word(5 + actual);
      ext_word(3 + actual);
      ext_bytes.push_back(name_type);
      ext_word(claimed);
      repeat (actual) ext_bytes.push_back($urandom_range(0, 255));
   endfunction

   function automatic void trim_packet(int unsigned keep);
      while (pkt.size() > keep) pkt.pop_back();
   endfunction

   // Build a ClientHello with random content and at most one planted fault.
   function automatic void build_hello(hello_flaw_e flaw, int unsigned name_len,
                                       int unsigned sid_len);
      int unsigned body;
      int unsigned total;
      bit          entry_bad;
      pkt.delete();
      ext_bytes.delete();
      for (int i = 0; i < POS_SESSION_ID_LEN; i++) pkt.push_back($urandom_range(0, 255));
      pkt[POS_RECORD_TYPE]   = REC_TYPE_HANDSHAKE;
      pkt[POS_VERSION_MAJOR] = REC_VERSION_MAJOR;
      pkt[POS_HS_TYPE]       = HS_CLIENT_HELLO;
      pkt.push_back(sid_len[7:0]);
      repeat (sid_len) pkt.push_back($urandom_range(0, 255));
      body = 2 * $urandom_range(1, 4);
      pkt.push_back(body[15:8]);
      pkt.push_back(body[7:0]);
      repeat (body) pkt.push_back($urandom_range(0, 255));
      body = $urandom_range(1, 2);
      pkt.push_back(body[7:0]);
      repeat (body) pkt.push_back($urandom_range(0, 255));

      // Extensions: leading filler, the server name part, trailing filler.
      if (flaw == FLAW_EXT_OVERRUN) begin
         add_plain_ext($urandom_range(64, 1000), 2);
      end
      repeat ($urandom_range(0, 2)) begin
         body = $urandom_range(0, 5);
         add_plain_ext(body, body);
      end
      entry_bad = 1'b1;
      case (flaw)
         FLAW_NAME_TYPE:     add_sni_ext($urandom_range(1, 255), name_len, name_len);
         FLAW_EMPTY_NAME:    add_sni_ext(NAME_TYPE_HOST, 0, $urandom_range(0, 3));
         FLAW_NAME_PAST_EXT: add_sni_ext(NAME_TYPE_HOST, name_len + $urandom_range(1, 4),
                                         name_len);
         FLAW_SHORT_SNI_EXT: begin
            body = $urandom_range(0, SNI_MIN_EXT_LENGTH - 1);
            ext_word(EXT_SERVER_NAME);
            ext_word(body);
            repeat (body) ext_bytes.push_back($urandom_range(0, 255));
         end
         default: entry_bad = 1'b0;
      endcase
      // After a bad entry a good one usually follows, so parsing must carry on.
      if (!entry_bad || $urandom_range(0, 3) != 0) begin
         add_sni_ext(NAME_TYPE_HOST, name_len, name_len);
      end
      repeat ($urandom_range(0, 2)) begin
         body = $urandom_range(0, 5);
         add_plain_ext(body, body);
      end

      total = ext_bytes.size();
      if (flaw == FLAW_LIST_LONG) begin
         total += $urandom_range(1, 300);
      end else if (flaw == FLAW_LIST_SHORT) begin
         total -= $urandom_range(1, total);
      end
      pkt.push_back(total[15:8]);
      pkt.push_back(total[7:0]);
      foreach (ext_bytes[i]) pkt.push_back(ext_bytes[i]);
      pkt_len = pkt.size();
   endfunction

   // Short random packet with any length value.
   function automatic void build_noise();
      pkt.delete();
      repeat ($urandom_range(1, 12)) pkt.push_back($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 1) begin
         pkt[0] = REC_TYPE_HANDSHAKE;
      end
      pkt_len = $urandom_range(0, 16'hFFFF);
   endfunction

   // Offer one beat after a random gap and wait until it is taken.
   task automatic send_beat(req_type d);
      int gap;
      gap = send_no_gap ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(d);
   endtask

   // Send the built packet; the end mark rides on its last byte.
   task automatic send_packet(bit shift_len);
      int unsigned change_at;
      logic [15:0] alt_len;
      req_type     d;
      change_at   = shift_len ? $urandom_range(0, pkt.size() - 1) : pkt.size();
      alt_len     = $urandom_range(0, 16'hFFFF);
      send_no_gap = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < pkt.size(); i++) begin
         d.payload_byte   = pkt[i];
         d.payload_length = (i >= change_at) ? alt_len : pkt_len;
         d.end_of_packet  = (i == pkt.size() - 1);
         send_beat(d);
      end
      packets_sent++;
      bytes_sent += pkt.size();
   endtask

   // Hold off the sender until every expected result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_beats.size() != 0);
   endtask

   // Result side: random stalls, with stall-free stretches now and then.
   initial begin
      int stall;
      int left_in_mode;
      bit no_stall;
      rsp_ready    = 1'b0;
      left_in_mode = 0;
      no_stall     = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (left_in_mode == 0) begin
            no_stall     = ($urandom_range(0, 3) == 0);
            left_in_mode = $urandom_range(8, 64);
         end
         left_in_mode--;
         stall = no_stall ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_beat(rsp_data);
      end
   end

   // Reset, directed packets, random packets, then the verdict on the run.
   initial begin
      int f;
      int pick;
      int idx;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      sb.clear();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Plain hello with a one-character name and no session ID.
      build_hello(FLAW_NONE, 1, 0);
      send_packet(1'b0);
      // Names that just fit the kept limit and that get truncated.
      build_hello(FLAW_NONE, NAME_LIMIT - 1, 32);
      send_packet(1'b0);
      build_hello(FLAW_NONE, 300, 5);
      send_packet(1'b0);
      // Every bad server_name entry and every extension list fault.
      for (f = FLAW_NAME_TYPE; f <= FLAW_LIST_SHORT; f++) begin
         build_hello(hello_flaw_e'(f), 8, 4);
         send_packet(1'b0);
      end
      // Length just below the minimum.
      build_hello(FLAW_NONE, 4, 0);
      pkt_len = MIN_PAYLOAD_LENGTH - 1;
      send_packet(1'b0);
      // Wrong record type, version and handshake type.
      build_hello(FLAW_NONE, 4, 0);
      pkt[POS_RECORD_TYPE] = ~REC_TYPE_HANDSHAKE;
      send_packet(1'b0);
      build_hello(FLAW_NONE, 4, 0);
      pkt[POS_VERSION_MAJOR] = ~REC_VERSION_MAJOR;
      send_packet(1'b0);
      build_hello(FLAW_NONE, 4, 0);
      pkt[POS_HS_TYPE] = ~HS_CLIENT_HELLO;
      send_packet(1'b0);
      // Session ID that runs past the payload length.
      build_hello(FLAW_NONE, 4, 200);
      trim_packet(100);
      pkt_len = 100;
      send_packet(1'b0);
      // Packet cut short by five bytes, so the end mark can fall inside the name.
      build_hello(FLAW_NONE, 12, 0);
      trim_packet(pkt.size() - 5);
      send_packet(1'b0);
      // Trailing bytes past the length before the end mark.
      build_hello(FLAW_NONE, 6, 0);
      repeat (5) pkt.push_back($urandom_range(0, 255));
      send_packet(1'b0);
      // Length that changes partway through a packet.
      build_hello(FLAW_NONE, 10, 3);
      send_packet(1'b1);
      // Single byte at full-scale length, then an all-zero packet.
      pkt.delete();
      pkt.push_back(8'hFF);
      pkt_len = 16'hFFFF;
      send_packet(1'b0);
      pkt.delete();
      repeat (50) pkt.push_back(8'h00);
      pkt_len = '0;
      send_packet(1'b0);
      wait_drained();

      // Random part: hellos, well-formed or with a planted fault, some damaged further or noise.
      while (bytes_sent < RANDOM_BYTES + 700 || packets_sent < RANDOM_PACKETS + 20) begin
         pick = $urandom_range(0, 99);
         build_hello(($urandom_range(0, 1) == 1) ? FLAW_NONE :
                     hello_flaw_e'($urandom_range(FLAW_NAME_TYPE, FLAW_LIST_SHORT)),
                     ($urandom_range(0, 29) == 0) ? $urandom_range(200, 300)
                                                  : $urandom_range(1, 24),
                     $urandom_range(0, 32));
         if (pick >= 92) begin
            build_noise();
         end else if (pick >= 86) begin
            repeat ($urandom_range(1, 8)) pkt.push_back($urandom_range(0, 255));
         end else if (pick >= 78) begin
            if ($urandom_range(0, 1) == 1) begin
               pkt_len = pkt.size() - $urandom_range(1, 60);
            end else begin
               pkt_len = pkt.size() + $urandom_range(1, 2000);
            end
         end else if (pick >= 70) begin
            trim_packet($urandom_range(1, pkt.size() - 1));
         end else if (pick >= 60) begin
            idx = $urandom_range(0, pkt.size() - 1);
            pkt[idx] = pkt[idx] ^ $urandom_range(1, 255);
         end
         send_packet($urandom_range(0, 15) == 0);
         if ($urandom_range(0, 7) == 0) begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d packets (%0d payload bytes): headers, skips, extension faults,",
               packets_sent, bytes_sent);
      $display("truncation and early ends; checked %0d name beats, %0d verdicts, %0d hosts.",
               sb.name_beats, sb.verdict_beats, sb.hosts_found);
      if (sb.mismatches == 0) begin
         $display("PASS tls_client_hello_sni_extractor");
      end else begin
         $display("FAIL tls_client_hello_sni_extractor");
      end
      $finish;
   end

endmodule

// File: tls_client_hello_sni_extractor.f
sv/tcse_pkg.sv
sv/tcse_parse.sv
sv/tcse_fifo.sv
sv/tcse_emit.sv
sv/tls_client_hello_sni_extractor.sv
sv/tcse_checker.sv
test/tb_top.sv
